[rtl/swfit_pkg.sv]
// Shared types and constants for the sliding-window linear fit block.
// No dependencies; imported by the top level.
package swfit_pkg;

  localparam int FRAC    = 16;
  localparam int TIME_W  = 32;
  localparam int VAL_W   = 32;
  localparam int SLOPE_W = 48;

  localparam logic [SLOPE_W-1:0] SAT48_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SAT48_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
  localparam logic [VAL_W-1:0]   SAT32_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0]   SAT32_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SUM_RD  = 9'b000000010,
    S_SUM_TV  = 9'b000000100,
    S_SUM_TT  = 9'b000001000,
    S_SUM_ACC = 9'b000010000,
    S_CALC    = 9'b000100000,
    S_RUN     = 9'b001000000,
    S_POST    = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  typedef enum logic [10:0] {
    ST_NSTV  = 11'b00000000001,
    ST_STSV  = 11'b00000000010,
    ST_NSTT  = 11'b00000000100,
    ST_STST  = 11'b00000001000,
    ST_SLOPE = 11'b00000010000,
    ST_SST   = 11'b00000100000,
    ST_ICPT  = 11'b00001000000,
    ST_SEVAL = 11'b00010000000,
    ST_FIT   = 11'b00100000000,
    ST_AVGV  = 11'b01000000000,
    ST_AVGT  = 11'b10000000000
  } step_t;

endpackage

[rtl/swfit_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module swfit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sliding_window_linear_fit.sv]
// Sliding-window least-squares line fit, top level.
// Depends on swfit_pkg and swfit_ram.
//
// Usage
// -----
// The input channel (in_valid / in_ready) carries one item per request. An
// item with op 0 stores its sample over the oldest slot of a ring of WINDOW
// (time, value) slots and then evaluates; an item with op 1 only evaluates.
// Each item yields exactly one result item on the output channel
// (out_valid / out_ready): fitted value, slope, intercept and both means.
//
// The block works on one item at a time and drops in_ready while it does.
// An item first takes a pass through the ring RAM, each slot in turn through
// the read, t*v, t*t and accumulate states, then a chain of wide multiplies
// and divides on one shared shift-add / restoring-divide unit that retires
// one bit per cycle. The shared word is AW = 82 + 2*NB bits wide (NB the bit
// count of WINDOW).
//
// The result sits in an output register, so in_ready returns as soon as the
// result is loaded, even while the receiver stalls; a second finished result
// waits in the sequencer until the first one has been taken.
// Reset is synchronous: all slots read as zero (per-slot valid bits), the
// write slot returns to zero and no result is pending.
module sliding_window_linear_fit
  import swfit_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [31:0]        sample_time,
  input  logic signed [31:0] sample_value,
  input  logic               use_latest_time,
  input  logic [31:0]        eval_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] fitted_value,
  output logic signed [47:0] slope,
  output logic signed [47:0] intercept,
  output logic signed [31:0] avg_value,
  output logic [31:0]        avg_time
);

  // Widths of the sums and of the shared arithmetic word.
  localparam int AB    = $clog2(WINDOW);
  localparam int NB    = $clog2(WINDOW + 1);
  localparam int ST_W  = TIME_W + NB;
  localparam int STV_W = 2 * TIME_W + NB;
  localparam int AW    = 82 + 2 * NB;
  localparam int CW    = $clog2(AW + 1);

  localparam logic [AW-1:0] N_AW  = AW'(WINDOW);
  localparam logic [AW-1:0] N_DIV = AW'(WINDOW) << FRAC;
  localparam logic [AW-1:0] RND   = AW'((1 << FRAC) - 1);

  state_t state;
  step_t  step;

  logic [AB-1:0]     idx;
  logic [AB-1:0]     ws;
  logic [AB-1:0]     ws_next;
  logic [WINDOW-1:0] vld;
  logic              vld_q;

  logic        cap_latest;
  logic [31:0] cap_eval;
  logic [31:0] latest_t;
  logic [31:0] cur_t;
  logic [63:0] prod;

  logic [ST_W-1:0]         st;
  logic signed [ST_W-1:0]  sv;
  logic signed [STV_W-1:0] stv;
  logic [STV_W-1:0]        stt;

  logic signed [AW-1:0] num;
  logic [AW-1:0]        den;
  logic signed [47:0]   slope_w;
  logic signed [47:0]   icpt_w;
  logic [31:0]          fit_w;
  logic [31:0]          avgv_w;

  // Shared multiply / divide unit.
  logic [AW-1:0]        opa;
  logic [AW-1:0]        opb;
  logic [AW:0]          acc;
  logic [CW-1:0]        cnt;
  logic                 eneg;
  logic                 ediv;
  logic signed [AW-1:0] eres;

  logic                 accept_in;
  logic                 ram_we;
  logic [63:0]          rdata;

  logic [31:0]          t_rd;
  logic [31:0]          v_rd;
  logic signed [32:0]   ma;
  logic signed [32:0]   mb;
  logic signed [65:0]   mp;

  logic signed [AW-1:0] ea;
  logic signed [AW-1:0] eb;
  logic                 ediv_c;
  logic [AW-1:0]        a_mag;
  logic [AW-1:0]        b_mag;

  logic [AW:0]          lhs;
  logic [AW:0]          addend;
  logic [AW+1:0]        sum;
  logic                 ge;
  logic                 edone;
  logic [AW-1:0]        emag;

  logic [31:0]          t_eval;
  logic signed [AW-1:0] fsum;
  logic signed [AW-1:0] fshift;

  function automatic logic [47:0] sat48(input logic [AW-1:0] x);
    logic [AW-48:0] top;
    top = x[AW-1:47];
    if ((&top) || !(|top)) begin
      return x[47:0];
    end
    return x[AW-1] ? SAT48_MIN : SAT48_MAX;
  endfunction

  function automatic logic [31:0] sat32(input logic [AW-1:0] x);
    logic [AW-32:0] top;
    top = x[AW-1:31];
    if ((&top) || !(|top)) begin
      return x[31:0];
    end
    return x[AW-1] ? SAT32_MIN : SAT32_MAX;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept_in = in_valid && in_ready;
  assign ram_we    = accept_in && !op;
  assign ws_next   = (ws == AB'(WINDOW - 1)) ? '0 : ws + 1'b1;

  swfit_ram #(
    .WIDTH(64),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ws_next),
    .wdata({sample_time, sample_value}),
    .raddr(idx),
    .rdata(rdata)
  );

  // Slots never written since reset read as zero.
  assign t_rd = vld_q ? rdata[63:32] : '0;
  assign v_rd = vld_q ? rdata[31:0] : '0;

  // One 33x33 multiplier: t*v in the S_SUM_TV state of a slot, t*t in S_SUM_TT.
  always_comb begin
    if (state == S_SUM_TV) begin
      ma = $signed({1'b0, t_rd});
      mb = $signed({v_rd[31], v_rd});
    end else begin
      ma = $signed({1'b0, cur_t});
      mb = $signed({1'b0, cur_t});
    end
    mp = ma * mb;
  end

  assign t_eval = cap_latest ? latest_t : cap_eval;

  // Operands of the shared unit for each step of the sequence.
  always_comb begin
    ea     = '0;
    eb     = '0;
    ediv_c = 1'b0;
    unique case (step)
      ST_NSTV: begin
        ea = AW'(stv);
        eb = $signed(N_AW);
      end
      ST_STSV: begin
        ea = AW'(sv);
        eb = $signed({{(AW-ST_W){1'b0}}, st});
      end
      ST_NSTT: begin
        ea = $signed({{(AW-STV_W){1'b0}}, stt});
        eb = $signed(N_AW);
      end
      ST_STST: begin
        ea = $signed({{(AW-ST_W){1'b0}}, st});
        eb = $signed({{(AW-ST_W){1'b0}}, st});
      end
      ST_SLOPE: begin
        ea     = num <<< FRAC;
        eb     = $signed(den);
        ediv_c = 1'b1;
      end
      ST_SST: begin
        ea = AW'(slope_w);
        eb = $signed({{(AW-ST_W){1'b0}}, st});
      end
      ST_ICPT: begin
        ea     = num;
        eb     = $signed(N_DIV);
        ediv_c = 1'b1;
      end
      ST_SEVAL: begin
        ea = AW'(slope_w);
        eb = $signed({{(AW-32){1'b0}}, t_eval});
      end
      ST_AVGV: begin
        ea     = AW'(sv);
        eb     = $signed(N_AW);
        ediv_c = 1'b1;
      end
      ST_AVGT: begin
        ea     = $signed({{(AW-ST_W){1'b0}}, st});
        eb     = $signed(N_AW);
        ediv_c = 1'b1;
      end
      default: begin
        ea = '0;
      end
    endcase
    a_mag = ea[AW-1] ? AW'(-ea) : AW'(ea);
    b_mag = eb[AW-1] ? AW'(-eb) : AW'(eb);
  end

  // One adder serves both the shift-add multiply and the restoring divide.
  always_comb begin
    lhs    = ediv ? {acc[AW-1:0], opb[AW-1]} : acc;
    addend = ediv ? ~{1'b0, opa} : {1'b0, opa};
    sum    = {1'b0, lhs} + {1'b0, addend} + (AW+2)'(ediv);
    ge     = sum[AW+1];
    edone  = ediv ? (cnt == '0) : (opb == '0);
    emag   = ediv ? opb : acc[AW-1:0];
  end

  // Truncation of the fitted sum toward zero before dropping the fraction.
  assign fsum   = num + (num[AW-1] ? $signed(RND) : $signed({AW{1'b0}}));
  assign fshift = fsum >>> FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_NSTV;
      ws        <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      // The finish state reloads the output register itself when it is taken.
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept_in) begin
            if (!op) begin
              ws           <= ws_next;
              vld[ws_next] <= 1'b1;
            end
            cap_latest <= use_latest_time;
            cap_eval   <= eval_time;
            idx        <= '0;
            st         <= '0;
            sv         <= '0;
            stv        <= '0;
            stt        <= '0;
            state      <= S_SUM_RD;
          end
        end

        S_SUM_RD: begin
          vld_q <= vld[idx];
          state <= S_SUM_TV;
        end

        S_SUM_TV: begin
          prod  <= mp[63:0];
          cur_t <= t_rd;
          st    <= st + ST_W'(t_rd);
          sv    <= sv + ST_W'($signed(v_rd));
          if (idx == ws) begin
            latest_t <= t_rd;
          end
          state <= S_SUM_TT;
        end

        S_SUM_TT: begin
          stv   <= stv + STV_W'($signed(prod));
          prod  <= mp[63:0];
          state <= S_SUM_ACC;
        end

        S_SUM_ACC: begin
          stt <= stt + STV_W'(prod);
          if (idx == AB'(WINDOW - 1)) begin
            step  <= ST_NSTV;
            state <= S_CALC;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SUM_RD;
          end
        end

        S_CALC: begin
          if (step == ST_SLOPE && den == '0) begin
            // All times equal: the line is flat.
            slope_w <= '0;
            step    <= ST_SST;
          end else if (step == ST_FIT) begin
            fit_w <= sat32(fshift);
            step  <= ST_AVGV;
          end else begin
            eneg <= ea[AW-1] ^ eb[AW-1];
            ediv <= ediv_c;
            if (ediv_c) begin
              opa <= b_mag;
              opb <= a_mag;
            end else begin
              opa <= a_mag;
              opb <= b_mag;
            end
            acc   <= '0;
            cnt   <= CW'(AW);
            state <= S_RUN;
          end
        end

        S_RUN: begin
          if (edone) begin
            eres  <= eneg ? $signed(AW'(-emag)) : $signed(emag);
            state <= S_POST;
          end else if (ediv) begin
            acc <= ge ? sum[AW:0] : lhs;
            opb <= {opb[AW-2:0], ge};
            cnt <= cnt - 1'b1;
          end else begin
            if (opb[0]) begin
              acc <= sum[AW:0];
            end
            opa <= opa << 1;
            opb <= opb >> 1;
          end
        end

        S_POST: begin
          state <= S_CALC;
          unique case (step)
            ST_NSTV: begin
              num  <= eres;
              step <= ST_STSV;
            end
            ST_STSV: begin
              num  <= num - eres;
              step <= ST_NSTT;
            end
            ST_NSTT: begin
              den  <= eres;
              step <= ST_STST;
            end
            ST_STST: begin
              den  <= den - eres;
              step <= ST_SLOPE;
            end
            ST_SLOPE: begin
              slope_w <= sat48(eres);
              step    <= ST_SST;
            end
            ST_SST: begin
              num  <= (AW'(sv) <<< FRAC) - eres;
              step <= ST_ICPT;
            end
            ST_ICPT: begin
              icpt_w <= sat48(eres);
              step   <= ST_SEVAL;
            end
            ST_SEVAL: begin
              num  <= eres + (AW'(icpt_w) <<< FRAC);
              step <= ST_FIT;
            end
            ST_AVGV: begin
              avgv_w <= eres[31:0];
              step   <= ST_AVGT;
            end
            ST_AVGT: begin
              avg_time <= avg_time;
              cur_t    <= eres[31:0];
              state    <= S_FINISH;
            end
            default: begin
              step <= ST_NSTV;
            end
          endcase
        end

        S_FINISH: begin
          // Hold the finished result until the output register is free.
          if (!out_valid || out_ready) begin
            fitted_value <= fit_w;
            slope        <= slope_w;
            intercept    <= icpt_w;
            avg_value    <= avgv_w;
            avg_time     <= cur_t;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
